// ===== src/vfbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel frame buffer engine package
// Field widths and command and axis codes shared by the engine's modules.
// ----------------------------------------------------------------------------
package vfbe_pkg;

    localparam int MODE_W    = 4;
    localparam int COORD_W   = 4;
    localparam int AXIS_W    = 2;
    localparam int PATTERN_W = 16;

    localparam logic [MODE_W-1:0] MODE_SET_VOXEL   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR_VOXEL = 4'd1;
    localparam logic [MODE_W-1:0] MODE_FLIP_VOXEL  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_READ_VOXEL  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_WRITE_VOXEL = 4'd4;
    localparam logic [MODE_W-1:0] MODE_SET_PLANE   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR_PLANE = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FILL        = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_SHIFT       = 4'd9;

    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_all;
    } vfbe_ram_ctrl_t;

endpackage

// ===== src/vfbe_row_ram.sv =====
// ----------------------------------------------------------------------------
// Voxel row memory
// Single-port-write, single-read row store with a registered read and one
// valid bit per row, so that rows never written since reset or a clear read
// as zero.
// ----------------------------------------------------------------------------
module vfbe_row_ram #(
    parameter int ROW_W  = 10,
    parameter int DEPTH  = 100,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  vfbe_pkg::vfbe_ram_ctrl_t ctrl,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic [ROW_W-1:0]        rd_row,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic [ROW_W-1:0]        wr_row
);
    import vfbe_pkg::*;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (ctrl.clear_all) begin
                valid_reg <= '0;
            end else if (ctrl.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== src/voxel_frame_buffer_engine_top.sv =====
// ----------------------------------------------------------------------------
// Voxel frame buffer engine
// Holds a cube of CUBE_DIM^3 one-bit voxels and executes one command per
// request: voxel set, clear, flip, read and write, plane set and clear,
// fill, clear all and shift by one along an axis.
//
// Usage: a command request enters on the s_ channel and yields exactly one
// result request on the m_ channel, m_voxel_bit, which carries the voxel for
// a read and 0 otherwise. Commands run one at a time. A voxel command reads
// its row, writes it back and then passes to the finish state. Plane, fill
// and shift commands walk every one of the CUBE_DIM^2 rows with a read and
// a write-back before they finish. Clear all and commands that do nothing
// go straight from acceptance to the finish state, which issues the result.
// A new request is taken while the previous result still waits; if the
// receiver stalls, the finished command holds in its last state until the
// output register frees up, and s_ready stays low meanwhile.
// Reset empties the cube at once through per-row valid bits, drops any
// pending result and returns the engine to idle.
// ----------------------------------------------------------------------------
module voxel_frame_buffer_engine_top #(
    parameter int CUBE_DIM = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [vfbe_pkg::MODE_W-1:0]     s_mode,
    input  logic [vfbe_pkg::COORD_W-1:0]    s_coord_x,
    input  logic [vfbe_pkg::COORD_W-1:0]    s_coord_y,
    input  logic [vfbe_pkg::COORD_W-1:0]    s_coord_z,
    input  logic [vfbe_pkg::AXIS_W-1:0]     s_axis_sel,
    input  logic [vfbe_pkg::COORD_W-1:0]    s_plane_index,
    input  logic                            s_shift_up,
    input  logic                            s_voxel_value,
    input  logic [vfbe_pkg::PATTERN_W-1:0]  s_fill_pattern,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_voxel_bit
);
    import vfbe_pkg::*;

    localparam int ROW_W     = CUBE_DIM;
    localparam int DEPTH     = CUBE_DIM * CUBE_DIM;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int DIM_W     = $clog2(CUBE_DIM);
    localparam logic [DIM_W-1:0]   DIM_LAST = DIM_W'(CUBE_DIM - 1);
    localparam logic [COORD_W:0]   DIM_LIM  = (COORD_W + 1)'(CUBE_DIM);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_WRITE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [DIM_W-1:0]      walk_z_reg, walk_z_next;
    logic [DIM_W-1:0]      walk_y_reg, walk_y_next;
    logic                  single_reg, single_next;
    logic                  descend_reg, descend_next;
    logic                  bit_reg, bit_next;
    logic                  m_bit_reg, m_bit_next;
    logic                  m_valid_reg, m_valid_next;

    logic [MODE_W-1:0]     mode_reg;
    logic [DIM_W-1:0]      x_reg;
    logic [AXIS_W-1:0]     axis_reg;
    logic [DIM_W-1:0]      plane_reg;
    logic                  up_reg;
    logic                  value_reg;
    logic [ROW_W-1:0]      pattern_reg;

    logic                  accept;
    logic                  coord_ok;
    logic                  plane_ok;
    logic                  walk_start;
    logic                  has_src;
    logic                  last_row;
    logic [DIM_W-1:0]      src_z, src_y;
    logic [ROW_W-1:0]      cur_row;
    logic [ROW_W-1:0]      new_row;
    logic [ROW_W-1:0]      x_bit;
    logic [ROW_W-1:0]      p_bit;
    logic                  plane_on;
    vfbe_ram_ctrl_t        ram_ctrl;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;

    function automatic logic [ADDR_W-1:0] row_addr(input logic [DIM_W-1:0] z,
                                                   input logic [DIM_W-1:0] y);
        row_addr = ADDR_W'(z) * ADDR_W'(CUBE_DIM) + ADDR_W'(y);
    endfunction

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_voxel_bit = m_bit_reg;

    assign coord_ok = ({1'b0, s_coord_x} < DIM_LIM) && ({1'b0, s_coord_y} < DIM_LIM)
                   && ({1'b0, s_coord_z} < DIM_LIM);
    assign plane_ok = ({1'b0, s_plane_index} < DIM_LIM) && (s_axis_sel != AXIS_NONE);

    always_comb begin
        walk_start = 1'b0;
        priority if (s_mode <= MODE_WRITE_VOXEL) begin
            walk_start = coord_ok;
        end else if (s_mode == MODE_SET_PLANE || s_mode == MODE_CLEAR_PLANE) begin
            walk_start = plane_ok;
        end else if (s_mode == MODE_FILL) begin
            walk_start = 1'b1;
        end else if (s_mode == MODE_SHIFT) begin
            walk_start = (s_axis_sel != AXIS_NONE);
        end else begin
            walk_start = 1'b0;
        end
    end

    always_comb begin
        has_src = 1'b0;
        src_z   = walk_z_reg;
        src_y   = walk_y_reg;
        if (mode_reg == MODE_SHIFT && axis_reg == AXIS_Y) begin
            has_src = up_reg ? (walk_y_reg != '0) : (walk_y_reg != DIM_LAST);
            if (has_src) begin
                src_y = up_reg ? walk_y_reg - 1'b1 : walk_y_reg + 1'b1;
            end
        end else if (mode_reg == MODE_SHIFT && axis_reg == AXIS_Z) begin
            has_src = up_reg ? (walk_z_reg != '0) : (walk_z_reg != DIM_LAST);
            if (has_src) begin
                src_z = up_reg ? walk_z_reg - 1'b1 : walk_z_reg + 1'b1;
            end
        end
    end

    assign rd_addr = row_addr(src_z, src_y);
    assign wr_addr = row_addr(walk_z_reg, walk_y_reg);

    assign x_bit    = ROW_W'(1) << x_reg;
    assign p_bit    = ROW_W'(1) << plane_reg;
    assign plane_on = (mode_reg == MODE_SET_PLANE);

    always_comb begin
        new_row = cur_row;
        unique case (mode_reg)
            MODE_SET_VOXEL:   new_row = cur_row | x_bit;
            MODE_CLEAR_VOXEL: new_row = cur_row & ~x_bit;
            MODE_FLIP_VOXEL:  new_row = cur_row ^ x_bit;
            MODE_WRITE_VOXEL: new_row = value_reg ? (cur_row | x_bit) : (cur_row & ~x_bit);
            MODE_SET_PLANE, MODE_CLEAR_PLANE: begin
                unique case (axis_reg)
                    AXIS_X: new_row = plane_on ? (cur_row | p_bit) : (cur_row & ~p_bit);
                    AXIS_Y: begin
                        if (walk_y_reg == plane_reg) begin
                            new_row = plane_on ? '1 : '0;
                        end
                    end
                    AXIS_Z: begin
                        if (walk_z_reg == plane_reg) begin
                            new_row = plane_on ? '1 : '0;
                        end
                    end
                    default: new_row = cur_row;
                endcase
            end
            MODE_FILL: new_row = pattern_reg;
            MODE_SHIFT: begin
                if (axis_reg == AXIS_X) begin
                    new_row = up_reg ? {cur_row[ROW_W-2:0], 1'b0} : {1'b0, cur_row[ROW_W-1:1]};
                end else begin
                    new_row = has_src ? cur_row : '0;
                end
            end
            default: new_row = cur_row;
        endcase
    end

    always_comb begin
        if (single_reg) begin
            last_row = 1'b1;
        end else if (descend_reg) begin
            last_row = (walk_z_reg == '0) && (walk_y_reg == '0);
        end else begin
            last_row = (walk_z_reg == DIM_LAST) && (walk_y_reg == DIM_LAST);
        end
    end

    always_comb begin
        state_next   = state_reg;
        walk_z_next  = walk_z_reg;
        walk_y_next  = walk_y_reg;
        single_next  = single_reg;
        descend_next = descend_reg;
        bit_next     = bit_reg;
        m_bit_next   = m_bit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_ctrl     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    bit_next     = 1'b0;
                    single_next  = (s_mode <= MODE_WRITE_VOXEL);
                    descend_next = (s_mode == MODE_SHIFT) && s_shift_up
                                && (s_axis_sel != AXIS_X);
                    ram_ctrl.clear_all = (s_mode == MODE_CLEAR_ALL);
                    if (s_mode <= MODE_WRITE_VOXEL) begin
                        walk_z_next = s_coord_z[DIM_W-1:0];
                        walk_y_next = s_coord_y[DIM_W-1:0];
                    end else if (descend_next) begin
                        walk_z_next = DIM_LAST;
                        walk_y_next = DIM_LAST;
                    end else begin
                        walk_z_next = '0;
                        walk_y_next = '0;
                    end
                    state_next = walk_start ? ST_READ : ST_FINISH;
                end
            end
            ST_READ: begin
                ram_ctrl.rd_en = 1'b1;
                state_next     = ST_WRITE;
            end
            ST_WRITE: begin
                ram_ctrl.wr_en = 1'b1;
                if (mode_reg == MODE_READ_VOXEL) begin
                    bit_next = cur_row[x_reg];
                end
                if (last_row) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_READ;
                    if (descend_reg) begin
                        if (walk_y_reg == '0) begin
                            walk_y_next = DIM_LAST;
                            walk_z_next = walk_z_reg - 1'b1;
                        end else begin
                            walk_y_next = walk_y_reg - 1'b1;
                        end
                    end else begin
                        if (walk_y_reg == DIM_LAST) begin
                            walk_y_next = '0;
                            walk_z_next = walk_z_reg + 1'b1;
                        end else begin
                            walk_y_next = walk_y_reg + 1'b1;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_bit_next   = bit_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            single_reg  <= 1'b0;
            descend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            single_reg  <= single_next;
            descend_reg <= descend_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_z_reg <= walk_z_next;
        walk_y_reg <= walk_y_next;
        bit_reg    <= bit_next;
        m_bit_reg  <= m_bit_next;
        if (accept) begin
            mode_reg    <= s_mode;
            x_reg       <= s_coord_x[DIM_W-1:0];
            axis_reg    <= s_axis_sel;
            plane_reg   <= s_plane_index[DIM_W-1:0];
            up_reg      <= s_shift_up;
            value_reg   <= s_voxel_value;
            pattern_reg <= s_fill_pattern[ROW_W-1:0];
        end
    end

    vfbe_row_ram #(
        .ROW_W  (ROW_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_row_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ram_ctrl),
        .rd_addr (rd_addr),
        .rd_row  (cur_row),
        .wr_addr (wr_addr),
        .wr_row  (new_row)
    );

endmodule
